// ===== rtl/pcsp_pkg.sv =====
// Shared types and constants of the potentiometer step pulser.
// No dependencies; imported by every module of the block.
package pcsp_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_ALPHA     = 3'd0;
    localparam logic [2:0] REG_FAST_US   = 3'd1;
    localparam logic [2:0] REG_SLOW_US   = 3'd2;
    localparam logic [2:0] REG_DEBOUNCE  = 3'd3;
    localparam logic [2:0] REG_DIRECTION = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_W      = 16;

    // Datapath operations, one per controller step
    localparam logic [2:0] OP_IDLE  = 3'd0;
    localparam logic [2:0] OP_SEED  = 3'd1;
    localparam logic [2:0] OP_EMA_A = 3'd2;
    localparam logic [2:0] OP_EMA_B = 3'd3;
    localparam logic [2:0] OP_EMA_C = 3'd4;
    localparam logic [2:0] OP_IVL_A = 3'd5;
    localparam logic [2:0] OP_IVL_B = 3'd6;
    localparam logic [2:0] OP_CMP   = 3'd7;

    // Shared multiplier operand width
    localparam int MW = 27;

    localparam logic [8:0]  ALPHA_ONE = 9'd256;
    // x / 960 = ((x >> 6) * RECIP15) >> 30, exact for x >> 6 below 2^26
    localparam int          DIV_PRE       = 6;
    localparam int          RECIP15_SHIFT = 30;
    localparam logic [26:0] RECIP15       = 27'd71582789;
    localparam int          Q_W           = 23;
    // (y * 106) / 999 = (y * RECIP_PCT) >> 20, exact for y up to 951
    localparam int          PCT_SHIFT = 20;
    localparam logic [26:0] RECIP_PCT = 27'd111261;
    localparam logic [16:0] PCT_SAT_E = 17'd953;
    localparam logic [6:0]  PCT_MAX   = 7'd100;

    typedef struct packed {
        logic       load;
        logic [2:0] op;
        logic       fin;
    } t_cmd;

    typedef struct packed {
        logic seeded;
    } t_sts;

endpackage

// ===== rtl/pcsp_ctrl.sv =====
// Sequencer of the step pulser: walks the datapath through one item.
// Depends on pcsp_pkg; drives pcsp_dp by command struct.
module pcsp_ctrl
    import pcsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SEED  = 4'd1;
    localparam logic [3:0] S_EMA_A = 4'd2;
    localparam logic [3:0] S_EMA_B = 4'd3;
    localparam logic [3:0] S_EMA_C = 4'd4;
    localparam logic [3:0] S_IVL_A = 4'd5;
    localparam logic [3:0] S_IVL_B = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept, out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd       = '{load: accept, op: OP_IDLE, fin: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_sts.seeded ? S_EMA_A : S_SEED;
                end
            end
            S_SEED: begin
                o_cmd.op = OP_SEED;
                n_state  = S_CMP;
            end
            S_EMA_A: begin
                o_cmd.op = OP_EMA_A;
                n_state  = S_EMA_B;
            end
            S_EMA_B: begin
                o_cmd.op = OP_EMA_B;
                n_state  = S_EMA_C;
            end
            S_EMA_C: begin
                o_cmd.op = OP_EMA_C;
                n_state  = S_IVL_A;
            end
            S_IVL_A: begin
                o_cmd.op = OP_IVL_A;
                n_state  = S_IVL_B;
            end
            S_IVL_B: begin
                o_cmd.op = OP_IVL_B;
                n_state  = S_CMP;
            end
            S_CMP: begin
                o_cmd.op = OP_CMP;
                n_state  = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/pcsp_dp.sv =====
// Datapath of the step pulser: configuration, filter, interval and percent
// arithmetic on one shared multiplier, and the result register.
// Depends on pcsp_pkg; sequenced by pcsp_ctrl.
module pcsp_dp
    import pcsp_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_button,
    input  logic [31:0]            i_now_us,
    input  logic [31:0]            i_now_ms,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    output logic                   o_step_pulse,
    output logic                   o_enable_level,
    output logic                   o_direction_level,
    output logic                   o_percent_valid,
    output logic [6:0]             o_speed_percent
);

    localparam int FW = SAMPLE_BITS + 8;

    // configuration
    logic [8:0]  r_alpha;
    logic [15:0] r_fast, r_slow, r_debounce;
    logic        r_dir;

    // item registers
    logic [SAMPLE_BITS-1:0] r_s;
    logic                   r_btn;
    logic [31:0]            r_us, r_ms;

    // state
    logic             r_seeded, r_stop, r_en;
    logic [FW-1:0]    r_f, r_acc;
    logic [31:0]      r_last_step, r_last_press;
    logic [6:0]       r_shown;

    // working registers
    logic [2*MW-1:0]  r_prod;
    logic             r_neg, r_step, r_pclamp;
    logic [15:0]      r_mag;

    // result register
    logic       r_o_pulse, r_o_en, r_o_dir, r_o_pv;
    logic [6:0] r_o_pct;

    logic [8:0]             a_eff;
    logic [MW-1:0]          mul_a, mul_b;
    logic                   mul_en;
    logic [SAMPLE_BITS-1:0] e;
    logic [16:0]            e17;
    logic [9:0]             y;
    logic [Q_W-1:0]         q;
    logic [23:0]            fast24, q24, ival;
    logic [6:0]             p;
    logic                   pct_moved, press;

    assign a_eff  = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign e      = r_f[FW-1:8];
    assign e17    = 17'(e);
    assign y      = (e17 == 17'd0) ? 10'd0 : 10'(e17 - 17'd1);
    assign q      = r_prod[RECIP15_SHIFT +: Q_W];
    assign fast24 = 24'(r_fast);
    assign q24    = 24'(q);
    assign ival   = r_neg ? ((q24 > fast24) ? 24'd0 : fast24 - q24) : fast24 + q24;
    assign p      = r_pclamp ? PCT_MAX : r_prod[PCT_SHIFT +: 7];

    assign pct_moved = (({1'b0, p} + 8'd1) < {1'b0, r_shown}) ||
                       ({1'b0, p} > ({1'b0, r_shown} + 8'd1));
    assign press     = ((r_ms - r_last_press) > 32'(r_debounce)) && r_btn;

    // operand selection for the shared multiplier
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (i_cmd.op)
            OP_EMA_A: begin
                mul_a = MW'(ALPHA_ONE - a_eff);
                mul_b = MW'(r_f);
            end
            OP_EMA_B: begin
                mul_a = MW'(a_eff);
                mul_b = MW'(r_s);
            end
            OP_IVL_A: begin
                mul_a = MW'(e);
                mul_b = MW'(r_mag);
            end
            OP_IVL_B: begin
                mul_a = MW'(r_prod[SAMPLE_BITS+15:DIV_PRE]);
                mul_b = RECIP15;
            end
            OP_CMP: begin
                mul_a = MW'(y);
                mul_b = RECIP_PCT;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= 9'd64;
            r_fast     <= 16'd500;
            r_slow     <= 16'd5000;
            r_debounce <= 16'd200;
            r_dir      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ALPHA:     r_alpha    <= i_cfg_data[8:0];
                REG_FAST_US:   r_fast     <= i_cfg_data;
                REG_SLOW_US:   r_slow     <= i_cfg_data;
                REG_DEBOUNCE:  r_debounce <= i_cfg_data;
                REG_DIRECTION: r_dir      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s   <= i_sample;
            r_btn <= i_button;
            r_us  <= i_now_us;
            r_ms  <= i_now_ms;
        end
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        case (i_cmd.op)
            OP_EMA_B: r_acc <= r_prod[8 +: FW];
            OP_EMA_C: begin
                r_neg <= r_slow < r_fast;
                r_mag <= (r_slow < r_fast) ? r_fast - r_slow : r_slow - r_fast;
            end
            OP_CMP: begin
                r_step   <= r_seeded && ((r_us - r_last_step) > 32'(ival));
                r_pclamp <= e17 >= PCT_SAT_E;
            end
            default: ;
        endcase
        if (i_cmd.fin) begin
            r_o_dir <= r_dir;
            if (!r_seeded) begin
                r_o_pulse <= 1'b0;
                r_o_pv    <= 1'b1;
                r_o_pct   <= p;
                r_o_en    <= r_en;
            end else begin
                r_o_pulse <= r_step;
                r_o_pv    <= r_step && pct_moved;
                r_o_pct   <= (r_step && pct_moved) ? p : r_shown;
                r_o_en    <= (r_step && press) ? !r_stop : r_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded     <= 1'b0;
            r_f          <= '0;
            r_last_step  <= '0;
            r_last_press <= '0;
            r_shown      <= '0;
            r_stop       <= 1'b0;
            r_en         <= 1'b1;
        end else begin
            case (i_cmd.op)
                OP_SEED:  r_f <= {r_s, 8'd0};
                OP_EMA_C: r_f <= r_acc + r_prod[FW-1:0];
                default: ;
            endcase
            if (i_cmd.fin) begin
                if (!r_seeded) begin
                    r_seeded <= 1'b1;
                    r_shown  <= p;
                end else if (r_step) begin
                    r_last_step <= r_us;
                    if (pct_moved) begin
                        r_shown <= p;
                    end
                    if (press) begin
                        r_last_press <= r_ms;
                        r_stop       <= !r_stop;
                        r_en         <= !r_stop;
                    end
                end
            end
        end
    end

    assign o_sts.seeded      = r_seeded;
    assign o_step_pulse      = r_o_pulse;
    assign o_enable_level    = r_o_en;
    assign o_direction_level = r_o_dir;
    assign o_percent_valid   = r_o_pv;
    assign o_speed_percent   = r_o_pct;

endmodule

// ===== rtl/pot_controlled_step_pulser.sv =====
// Top level of the potentiometer-controlled step pulser.
// Depends on pcsp_pkg, pcsp_ctrl and pcsp_dp.
//
// One beat in, one beat out. Each input beat carries a potentiometer sample,
// the stop-button level and free-running microsecond and millisecond times.
// The first beat after reset seeds the moving average with the sample and
// reports its speed percentage; every later beat updates the average with
// the Q0.8 weight in register 0, maps the integer reading linearly between
// the fast interval (reading 0) and the slow interval (reading 960),
// saturating at zero, and issues a step when more microseconds than that
// interval have passed since the last step. Only a stepping beat re-reports
// the percentage (when it moved by more than one) and looks at the button,
// which toggles a stop flag once per debounce window; the enable level then
// becomes the old flag inverted. An accepted item runs the steps EMA_A to
// FIN (SEED, CMP, FIN when seeding); its result is registered as FIN ends
// and the next input beat is taken only after that: every product of the
// filter, the interval map and the percentage passes through one shared
// registered multiplier, one product per cycle. Input is taken while a
// finished result still waits in the output register; a result waits in
// FIN only while the previous one has not been taken. Configuration
// writes are always ready and should be made only while the block is idle.
module pot_controlled_step_pulser
    import pcsp_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input beats
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // pot_sample[SAMPLE_BITS], button_level, now_us[32], now_ms[32], zero pad
    input  logic [((SAMPLE_BITS+65+7)/8)*8-1:0] i_s_tdata,
    // result beats
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // step_pulse, enable_level, direction_level, percent_valid,
    // speed_percent[7], zero pad
    output logic [OUT_W-1:0]      o_m_tdata,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int BTN_POS = SAMPLE_BITS;
    localparam int US_POS  = SAMPLE_BITS + 1;
    localparam int MS_POS  = SAMPLE_BITS + 33;

    t_cmd       cmd;
    t_sts       sts;
    logic       step_pulse, enable_level, direction_level, percent_valid;
    logic [6:0] speed_percent;

    assign o_cfg_ready = 1'b1;

    pcsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pcsp_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_sample          (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_button          (i_s_tdata[BTN_POS]),
        .i_now_us          (i_s_tdata[US_POS +: 32]),
        .i_now_ms          (i_s_tdata[MS_POS +: 32]),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_step_pulse      (step_pulse),
        .o_enable_level    (enable_level),
        .o_direction_level (direction_level),
        .o_percent_valid   (percent_valid),
        .o_speed_percent   (speed_percent)
    );

    // pack the result beat, lowest field first
    assign o_m_tdata = {5'd0, speed_percent, percent_valid, direction_level,
                        enable_level, step_pulse};

endmodule

// ===== rtl/pcsp_checker.sv =====
// Port-level checks of the step pulser, bound to the top level.
// Depends on pcsp_pkg and pot_controlled_step_pulser.
module pcsp_checker
    import pcsp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata
);

    // one item at a time: busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while an item is in flight");

    // a stalled result is kept
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result dropped under backpressure");

    // reported percentage is clamped
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[10:4] <= PCT_MAX))
        else $error("speed percentage above limit");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind pot_controlled_step_pulser pcsp_checker u_pcsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
